### hdl/csr_pkg.sv
// Shared types, constants and helper functions for the checksummed sentence receiver.
// No dependencies; used by every module of the block.
package csr_pkg;

  localparam int LINE_BUFFER_SIZE = 128;
  localparam int LC_W = $clog2(LINE_BUFFER_SIZE);
  localparam int NUM_TYPES = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    EV_GOOD     = 2'd0,
    EV_CSUM_ERR = 2'd1,
    EV_OVERFLOW = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    TY_WSTAT = 3'd0,
    TY_WACK  = 3'd1,
    TY_WNAK  = 3'd2,
    TY_WEVT  = 3'd3,
    TY_WERR  = 3'd4
  } stype_t;

  typedef struct packed {
    event_t     event_res;
    logic [2:0] sentence_type;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
  } result_t;

  localparam logic [7:0] PREFIX_TEXT [NUM_TYPES][7] = '{
    '{"$", "W", "S", "T", "A", "T", ","},
    '{"$", "W", "A", "C", "K", ",", 8'h00},
    '{"$", "W", "N", "A", "K", ",", 8'h00},
    '{"$", "W", "E", "V", "T", ",", 8'h00},
    '{"$", "W", "E", "R", "R", ",", 8'h00}
  };
  localparam logic [2:0] PREFIX_LEN [NUM_TYPES] = '{3'd7, 3'd6, 3'd6, 3'd6, 3'd6};

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

### hdl/csr_parser.sv
// Line state of the receiver: per-byte update and the end-of-line report.
// Depends on csr_pkg.
module csr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output csr_pkg::result_t  res
);
  import csr_pkg::*;

  localparam logic [LC_W-1:0] LC_LAST = LC_W'(LINE_BUFFER_SIZE - 1);

  logic [LC_W-1:0] line_count, line_count_next;
  logic            discarding, discarding_next;
  logic            starts_with_dollar, starts_with_dollar_next;
  logic [7:0]      running_xor, running_xor_next;
  logic            star_seen, star_seen_next;
  logic [1:0]      chars_after_star, chars_after_star_next;
  logic [15:0]     hex_chars, hex_chars_next;
  logic [4:0]      prefix_matches, prefix_matches_next;
  logic            nul_seen, nul_seen_next;

  logic            type_found;
  logic [2:0]      type_idx;
  logic [4:0]      h1, h2;
  logic [7:0]      received;

  always_comb begin
    type_found = 1'b0;
    type_idx   = 3'd0;
    for (int k = NUM_TYPES - 1; k >= 0; k--) begin
      if (prefix_matches[k] && line_count >= LC_W'(PREFIX_LEN[k])) begin
        type_found = 1'b1;
        type_idx   = 3'(k);
      end
    end
    h1 = hex_value(hex_chars[15:8]);
    h2 = hex_value(hex_chars[7:0]);
    received = 8'd0;
    if (star_seen && chars_after_star == 2'd2 && h1[4]) begin
      received = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
    end
  end

  always_comb begin
    line_count_next         = line_count;
    discarding_next         = discarding;
    starts_with_dollar_next = starts_with_dollar;
    running_xor_next        = running_xor;
    star_seen_next          = star_seen;
    chars_after_star_next   = chars_after_star;
    hex_chars_next          = hex_chars;
    prefix_matches_next     = prefix_matches;
    nul_seen_next           = nul_seen;
    res_valid = 1'b0;
    res       = '{EV_OVERFLOW, 3'd0, 8'd0, 8'd0};
    if (rx_byte == CH_DOLLAR) begin
      line_count_next = LC_W'(1);
      discarding_next = 1'b0;
      starts_with_dollar_next = 1'b1;
      running_xor_next = 8'd0;
      star_seen_next = 1'b0;
      chars_after_star_next = 2'd0;
      hex_chars_next = 16'd0;
      prefix_matches_next = 5'h1F;
      nul_seen_next = 1'b0;
    end else if (rx_byte == CH_CR) begin
    end else if (rx_byte == CH_LF || !discarding) begin
      if (rx_byte == CH_LF || line_count == LC_LAST) begin
        if (rx_byte == CH_LF) begin
          if (!discarding && line_count != '0 && starts_with_dollar && type_found) begin
            res_valid = 1'b1;
            res = '{(received == running_xor && star_seen && chars_after_star == 2'd2)
                    ? EV_GOOD : EV_CSUM_ERR, type_idx, running_xor, received};
          end
        end else begin
          res_valid = starts_with_dollar;
        end
        line_count_next = '0;
        discarding_next = (rx_byte != CH_LF);
        starts_with_dollar_next = 1'b0;
        running_xor_next = 8'd0;
        star_seen_next = 1'b0;
        chars_after_star_next = 2'd0;
        hex_chars_next = 16'd0;
        prefix_matches_next = 5'h1F;
        nul_seen_next = 1'b0;
      end else begin
        line_count_next = line_count + LC_W'(1);
        if (starts_with_dollar && !nul_seen) begin
          for (int k = 0; k < NUM_TYPES; k++) begin
            if (line_count < LC_W'(PREFIX_LEN[k]) && PREFIX_TEXT[k][line_count[2:0]] != rx_byte)
              prefix_matches_next[k] = 1'b0;
          end
          if (rx_byte == CH_NUL) begin
            nul_seen_next = 1'b1;
          end else if (!star_seen) begin
            if (rx_byte == CH_STAR) star_seen_next = 1'b1;
            else running_xor_next = running_xor ^ rx_byte;
          end else if (chars_after_star != 2'd2) begin
            hex_chars_next = {hex_chars[7:0], rx_byte};
            chars_after_star_next = chars_after_star + 2'd1;
          end
        end
      end
    end
    if (!step) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      discarding <= 1'b0;
      starts_with_dollar <= 1'b0;
      running_xor <= 8'd0;
      star_seen <= 1'b0;
      chars_after_star <= 2'd0;
      hex_chars <= 16'd0;
      prefix_matches <= 5'h1F;
      nul_seen <= 1'b0;
    end else if (step) begin
      line_count <= line_count_next;
      discarding <= discarding_next;
      starts_with_dollar <= starts_with_dollar_next;
      running_xor <= running_xor_next;
      star_seen <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      hex_chars <= hex_chars_next;
      prefix_matches <= prefix_matches_next;
      nul_seen <= nul_seen_next;
    end
  end

  a_disc_no_dollar: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !starts_with_dollar && line_count == '0)
    else $error("discarding with live line state");
  a_hex_after_star: assert property (@(posedge clk) disable iff (rst)
    chars_after_star != 2'd0 |-> star_seen && starts_with_dollar)
    else $error("hex characters without star");
  a_nul_in_dollar: assert property (@(posedge clk) disable iff (rst)
    nul_seen |-> starts_with_dollar)
    else $error("NUL tracked outside a dollar line");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= LC_LAST)
    else $error("line count past buffer");
  a_overflow_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_OVERFLOW |=> discarding)
    else $error("overflow report without discard");

endmodule

### hdl/csr_out_stage.sv
// Output register of the receiver: holds one report until the consumer takes it.
// Depends on csr_pkg.
module csr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  csr_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_res,
  output logic [2:0]        sentence_type,
  output logic [7:0]        computed_checksum,
  output logic [7:0]        received_checksum
);
  import csr_pkg::*;

  result_t held;

  assign free = !out_valid || !out_stall;
  assign event_res         = held.event_res;
  assign sentence_type     = held.sentence_type;
  assign computed_checksum = held.computed_checksum;
  assign received_checksum = held.received_checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
    if (free && load) held <= res;
  end

endmodule

### hdl/checksummed_sentence_receiver_core.sv
// Top level of the checksummed sentence receiver: input register, line parser, output register.
// Depends on csr_pkg, csr_parser, csr_out_stage.
//
//   channel | signals                     | direction | moves
//   in      | in_valid, in_stall, rx_byte | consumer  | one received byte per request
//   out     | out_valid, out_stall, fields| producer  | one report per typed line or overflow
//
// One byte per cycle unless the output stalls; accept to report via input then output register.
// The per-byte parser update is combinational compare and XOR logic.
// Synchronous reset clears the line state and both valid flags.
// in_stall rises only while a byte is held and the output register is stalled and full.
module checksummed_sentence_receiver_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] event_res,
  output logic [2:0] sentence_type,
  output logic [7:0] computed_checksum,
  output logic [7:0] received_checksum
);
  import csr_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign step     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
    if (in_valid && !in_stall) in_byte <= rx_byte;
  end

  csr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  csr_out_stage u_out (
    .clk               (clk),
    .rst               (rst),
    .load              (res_valid),
    .res               (res),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .event_res         (event_res),
    .sentence_type     (sentence_type),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum)
  );

endmodule
